// ===== rtl/dabdl_pkg.sv =====
// Package for the DAB dynamic label deframer.
// Holds shared types, header constants and the CRC-16 byte step.
// No dependencies.
package dabdl_pkg;

   // Group collection phase of the front part
   typedef enum logic [1:0] {
      PH_WAIT = 2'd0,
      PH_HEAD = 2'd1,
      PH_DATA = 2'd2
   } phase_type;

   // Result kinds as they leave on rsp_tuser
   typedef enum logic [1:0] {
      KIND_RESET = 2'd0,
      KIND_SEG   = 2'd1,
      KIND_CLEAR = 2'd2
   } rsp_kind_type;

   // Header bit positions and masks
   localparam int unsigned HDR_TOGGLE_BIT = 7;
   localparam int unsigned HDR_FIRST_BIT  = 6;
   localparam int unsigned HDR_LAST_BIT   = 5;
   localparam int unsigned HDR_CTRL_BIT   = 4;
   localparam logic [3:0]  CMD_CLEAR      = 4'b0000;

   // Group length bookkeeping
   localparam logic [4:0] CTRL_GROUP_LEN  = 5'd4;
   localparam logic [4:0] LABEL_GROUP_ADD = 5'd5;

   // CRC-16 CCITT, preset all ones, good-group residue
   localparam logic [15:0] CRC_POLY    = 16'h1021;
   localparam logic [15:0] CRC_PRESET  = 16'hFFFF;
   localparam logic [15:0] CRC_RESIDUE = 16'h1D0F;

   // One queued job: the results caused by one accepted beat
   typedef struct packed {
      rsp_kind_type kind;
      logic [2:0]   seg_num;
      logic [3:0]   charset;
      logic         first;
      logic         last;
      logic [3:0]   len_m1;
   } job_type;

   // Segment buffer write port, front to back
   typedef struct packed {
      logic       en;
      logic [3:0] addr;
      logic [7:0] data;
   } buf_wr_type;

   // Status from the back part
   typedef struct packed {
      logic seg_done;
   } back_status_type;

   // CRC-16 over one byte, MSB first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc_i,
                                            input logic [7:0]  data_i);
      logic [15:0] c;
      c = crc_i ^ {data_i, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== rtl/dabdl_front.sv =====
// Front part of the deframer: accepts X-PAD beats, tracks header, length and CRC.
// Posts one job per result-causing beat and writes the segment buffer.
// Depends on dabdl_pkg.
module dabdl_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic                      req_tuser,
   input  logic [7:0]                req_tdata,
   input  logic                      q_full,
   output logic                      q_push,
   output dabdl_pkg::job_type        q_job,
   output dabdl_pkg::buf_wr_type     buf_wr,
   input  dabdl_pkg::back_status_type back_status,
   output logic                      seg_pending
);

   dabdl_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  hdr0_ff, hdr0_in;
   logic [7:0]  hdr1_ff, hdr1_in;
   logic [4:0]  bc_ff, bc_in;
   logic [4:0]  req_len_ff, req_len_in;
   logic [15:0] crc_ff, crc_in;
   logic        toggle_ff, toggle_in;
   logic        seg_pend_ff, seg_pend_in;

   // Values as seen by this beat, after a possible restart
   dabdl_pkg::phase_type ph_cur;
   logic [4:0]  bc_cur, req_cur, bc_inc;
   logic [15:0] crc_cur, crc_nx;
   logic        acc, wr_cond, complete, crc_ok, hdr_second, is_ctrl, tog_change;
   logic [3:0]  f2;

   assign ph_cur  = req_tuser ? dabdl_pkg::PH_HEAD : phase_ff;
   assign bc_cur  = req_tuser ? 5'd0 : bc_ff;
   assign req_cur = req_tuser ? dabdl_pkg::CTRL_GROUP_LEN : req_len_ff;
   assign crc_cur = req_tuser ? dabdl_pkg::CRC_PRESET : crc_ff;
   assign crc_nx  = dabdl_pkg::crc_byte(crc_cur, req_tdata);
   assign bc_inc  = bc_cur + 5'd1;

   assign wr_cond    = (ph_cur == dabdl_pkg::PH_DATA) && (bc_cur >= 5'd2) &&
                       ({1'b0, bc_cur} + 6'd2 < {1'b0, req_cur});
   assign complete   = (bc_inc >= req_cur);
   assign crc_ok     = (crc_nx == dabdl_pkg::CRC_RESIDUE);
   assign hdr_second = (bc_cur == 5'd1);
   assign is_ctrl    = hdr0_ff[dabdl_pkg::HDR_CTRL_BIT];
   assign tog_change = hdr0_ff[dabdl_pkg::HDR_TOGGLE_BIT] != toggle_ff;
   assign f2         = hdr1_ff[7:4];

   // Hold off when the queue is full or a pending burst still reads the buffer
   assign req_tready = !q_full && !(seg_pend_ff && wr_cond);
   assign acc        = req_tvalid && req_tready;
   assign seg_pending = seg_pend_ff;

   // Phase next state
   always_comb begin
      phase_in = phase_ff;
      if (acc) begin
         case (ph_cur)
            dabdl_pkg::PH_HEAD: phase_in = hdr_second ? dabdl_pkg::PH_DATA
                                                      : dabdl_pkg::PH_HEAD;
            dabdl_pkg::PH_DATA: phase_in = complete ? dabdl_pkg::PH_WAIT
                                                    : dabdl_pkg::PH_DATA;
            default:            phase_in = dabdl_pkg::PH_WAIT;
         endcase
      end
   end

   // Datapath and outputs
   always_comb begin
      hdr0_in    = hdr0_ff;
      hdr1_in    = hdr1_ff;
      bc_in      = bc_ff;
      req_len_in = req_len_ff;
      crc_in     = crc_ff;
      toggle_in  = toggle_ff;
      q_push     = 1'b0;
      q_job      = '0;
      buf_wr.en   = acc && wr_cond;
      buf_wr.addr = 4'(bc_cur - 5'd2);
      buf_wr.data = req_tdata;
      if (acc) begin
         case (ph_cur)
            dabdl_pkg::PH_HEAD: begin
               if (hdr_second) begin
                  hdr1_in = req_tdata;
               end else begin
                  hdr0_in = req_tdata;
               end
               bc_in  = bc_inc;
               crc_in = crc_nx;
               if (hdr_second) begin
                  if (is_ctrl) begin
                     req_len_in = dabdl_pkg::CTRL_GROUP_LEN;
                  end else begin
                     req_len_in = dabdl_pkg::LABEL_GROUP_ADD + {1'b0, hdr0_ff[3:0]};
                     // toggle flip: label reset, ahead of the CRC
                     if (tog_change) begin
                        toggle_in    = hdr0_ff[dabdl_pkg::HDR_TOGGLE_BIT];
                        q_push       = 1'b1;
                        q_job.kind   = dabdl_pkg::KIND_RESET;
                     end
                  end
               end
            end
            dabdl_pkg::PH_DATA: begin
               bc_in      = bc_inc;
               crc_in     = crc_nx;
               req_len_in = req_cur;
               if (complete) begin
                  bc_in      = 5'd0;
                  req_len_in = dabdl_pkg::CTRL_GROUP_LEN;
                  crc_in     = dabdl_pkg::CRC_PRESET;
                  if (crc_ok) begin
                     if (is_ctrl) begin
                        if (hdr0_ff[3:0] == dabdl_pkg::CMD_CLEAR) begin
                           q_push     = 1'b1;
                           q_job.kind = dabdl_pkg::KIND_CLEAR;
                        end
                     end else begin
                        q_push        = 1'b1;
                        q_job.kind    = dabdl_pkg::KIND_SEG;
                        q_job.first   = hdr0_ff[dabdl_pkg::HDR_FIRST_BIT];
                        q_job.last    = hdr0_ff[dabdl_pkg::HDR_LAST_BIT];
                        q_job.seg_num = q_job.first ? 3'd0 : f2[2:0];
                        q_job.charset = q_job.first ? f2 : 4'd0;
                        q_job.len_m1  = hdr0_ff[3:0];
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Buffer ownership: set on a segment job, cleared when its last byte leaves
   always_comb begin
      seg_pend_in = seg_pend_ff;
      if (q_push && (q_job.kind == dabdl_pkg::KIND_SEG)) begin
         seg_pend_in = 1'b1;
      end else if (back_status.seg_done) begin
         seg_pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= dabdl_pkg::PH_WAIT;
         hdr0_ff     <= 8'd0;
         hdr1_ff     <= 8'd0;
         bc_ff       <= 5'd0;
         req_len_ff  <= dabdl_pkg::CTRL_GROUP_LEN;
         crc_ff      <= dabdl_pkg::CRC_PRESET;
         toggle_ff   <= 1'b0;
         seg_pend_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         hdr0_ff     <= hdr0_in;
         hdr1_ff     <= hdr1_in;
         bc_ff       <= bc_in;
         req_len_ff  <= req_len_in;
         crc_ff      <= crc_in;
         toggle_ff   <= toggle_in;
         seg_pend_ff <= seg_pend_in;
      end
   end

endmodule

// ===== rtl/dabdl_queue.sv =====
// Two-entry job queue between the front and back parts of the deframer.
// Depends on dabdl_pkg.
module dabdl_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  dabdl_pkg::job_type push_job,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output dabdl_pkg::job_type head_job
);

   dabdl_pkg::job_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_job   = entry_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/dabdl_back.sv =====
// Back part of the deframer: owns the segment buffer and expands jobs into result beats.
// Output register on the rsp side. Depends on dabdl_pkg.
module dabdl_back (
   input  logic                       clock,
   input  logic                       reset,
   input  dabdl_pkg::buf_wr_type      buf_wr,
   input  logic                       q_valid,
   input  dabdl_pkg::job_type         q_job,
   output logic                       q_pop,
   output dabdl_pkg::back_status_type back_status,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [23:0]                rsp_tdata,   // seg[2:0] cs[6:3] first[7] last[8] idx[12:9] payload[20:13]
   output logic [1:0]                 rsp_tuser,   // kind[1:0]
   output logic                       rsp_tlast
);

   logic [7:0] seg_buf_ff [16];

   dabdl_pkg::job_type cur_ff, cur_in;
   logic       active_ff, active_in;
   logic [3:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   logic [23:0] out_data_ff, out_data_in;
   logic [1:0] out_kind_ff, out_kind_in;
   logic       out_last_ff, out_last_in;
   logic       advance, last_res;

   // Segment buffer, written by the front part
   always_ff @(posedge clock) begin
      if (buf_wr.en) begin
         seg_buf_ff[buf_wr.addr] <= buf_wr.data;
      end
   end

   assign advance  = active_ff && (!out_valid_ff || rsp_tready);
   assign last_res = (cur_ff.kind != dabdl_pkg::KIND_SEG) || (idx_ff == cur_ff.len_m1);
   assign q_pop    = !active_ff && q_valid;
   assign back_status.seg_done = advance && last_res && (cur_ff.kind == dabdl_pkg::KIND_SEG);

   // Job expansion into the output register
   always_comb begin
      cur_in       = cur_ff;
      active_in    = active_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_kind_in  = out_kind_ff;
      out_last_in  = out_last_ff;
      if (q_pop) begin
         cur_in    = q_job;
         active_in = 1'b1;
         idx_in    = 4'd0;
      end else if (advance) begin
         out_valid_in = 1'b1;
         out_kind_in  = cur_ff.kind;
         out_last_in  = last_res;
         out_data_in  = '0;
         if (cur_ff.kind == dabdl_pkg::KIND_SEG) begin
            out_data_in[2:0]   = cur_ff.seg_num;
            out_data_in[6:3]   = cur_ff.charset;
            out_data_in[7]     = cur_ff.first;
            out_data_in[8]     = cur_ff.last;
            out_data_in[12:9]  = idx_ff;
            out_data_in[20:13] = seg_buf_ff[idx_ff];
         end
         idx_in    = last_res ? 4'd0 : idx_ff + 4'd1;
         active_in = !last_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         idx_ff       <= 4'd0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      out_data_ff <= out_data_in;
      out_kind_ff <= out_kind_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== rtl/dab_dynamic_label_deframer.sv =====
// DAB X-PAD dynamic label deframer, top level.
// A beat's first result passes the job queue, the job register and the output register.
// Throughput: one input beat per cycle while the job queue has room; the back part takes
// one job at a time; new segment data waits until the burst has read the segment buffer.
// Reset: synchronous, active high; waits for a start beat, toggle cleared, queue empty.
// Depends on dabdl_pkg, dabdl_front, dabdl_queue, dabdl_back.
module dab_dynamic_label_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte[7:0]
   input  logic        req_tuser,   // start_req
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // segment_number[2:0] charset[6:3] first_segment[7]
                                    // last_segment[8] byte_index[12:9] payload[20:13]
   output logic [1:0]  rsp_tuser,   // kind[1:0]
   output logic        rsp_tlast    // run_end
);

   logic                       q_full, q_push, q_pop, q_valid, seg_pending;
   dabdl_pkg::job_type         push_job, head_job;
   dabdl_pkg::buf_wr_type      buf_wr;
   dabdl_pkg::back_status_type back_status;

   dabdl_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_job       (push_job),
      .buf_wr      (buf_wr),
      .back_status (back_status),
      .seg_pending (seg_pending)
   );

   dabdl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (push_job),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_job   (head_job)
   );

   dabdl_back u_back (
      .clock       (clock),
      .reset       (reset),
      .buf_wr      (buf_wr),
      .q_valid     (q_valid),
      .q_job       (head_job),
      .q_pop       (q_pop),
      .back_status (back_status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

`ifndef SYNTHESIS
   // The buffer is never overwritten while a segment burst still owns it
   a_buf_owned: assert property (@(posedge clock) disable iff (reset)
      seg_pending |-> !buf_wr.en)
      else $error("segment buffer written during a pending burst");

   // No job is pushed into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push)
      else $error("job queue overflow");

   // Single-result kinds always close their run
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != dabdl_pkg::KIND_SEG)) |-> rsp_tlast)
      else $error("reset or clear result without run end");

   // A segment burst completion releases the buffer on the next cycle
   a_release: assert property (@(posedge clock) disable iff (reset)
      back_status.seg_done |=> !seg_pending)
      else $error("segment buffer not released");
`endif

endmodule
